// ===== rtl/core/mipu_pkg.sv =====
// ----------------------------------------------------------------------------
// mipu_pkg: shared types and constants of the interrupt priority unit
// Holds the command and result item layouts, the internal control structs
// and the codes for actions, bus accesses and the result sequencer.
// ----------------------------------------------------------------------------
package mipu_pkg;

  // Interrupt levels 1 to 7 each own one vector queue.
  localparam int NUM_LEVELS = 7;
  localparam logic [2:0] LEVEL_NMI = 3'd7;

  // Command actions.
  localparam logic [1:0] ACT_RAISE    = 2'd0;
  localparam logic [1:0] ACT_SERVICE  = 2'd1;
  localparam logic [1:0] ACT_WRITE_SR = 2'd2;
  localparam logic [1:0] ACT_WRITE_SP = 2'd3;

  // Bus access kinds.
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_LONG_WR = 2'd1;
  localparam logic [1:0] KIND_WORD_WR = 2'd2;
  localparam logic [1:0] KIND_VEC_RD  = 2'd3;

  // Result sequencer phases of an exception entry.
  localparam logic [1:0] PH_PC_WRITE = 2'd0;
  localparam logic [1:0] PH_SR_WRITE = 2'd1;
  localparam logic [1:0] PH_VEC_READ = 2'd2;

  // Status register layout and reset value.
  localparam int          SR_S_BIT    = 13;
  localparam logic [15:0] SR_RESET    = 16'h2700;
  localparam logic [31:0] FRAME_BYTES = 32'd6;
  localparam logic [31:0] PC_OFFSET   = 32'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  priority_req;
    logic [7:0]  vector_number;
    logic [31:0] operand_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  bus_kind;
    logic [31:0] bus_address;
    logic [31:0] bus_data;
    logic        last;
    logic [15:0] status_word;
    logic [31:0] stack_pointer;
    logic        pending;
    logic [2:0]  taken_level;
    logic        dropped;
  } res_t;

  // Queue control from the top level.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [2:0] push_level;
    logic [7:0] push_vec;
  } q_ctl_t;

  // Queue status back to the top level.
  typedef struct packed {
    logic       any;
    logic [2:0] top_level;
    logic       push_full;
    logic       left_after_pop;
  } q_stat_t;

  // Everything the result sequencer needs for one command.
  typedef struct packed {
    logic        service;
    logic [15:0] status_word;
    logic [31:0] stack_pointer;
    logic        pending;
    logic [2:0]  taken_level;
    logic        dropped;
    logic [31:0] pc;
    logic [15:0] old_sr;
  } load_t;

endpackage

// ===== rtl/core/mipu_ifs.sv =====
// ----------------------------------------------------------------------------
// mipu_ifs: valid/ready channels of the interrupt priority unit
// One interface for the command channel and one for the result channel.
// ----------------------------------------------------------------------------
interface mipu_cmd_if import mipu_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mipu_res_if import mipu_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/m68k_interrupt_priority_unit.sv =====
// ----------------------------------------------------------------------------
// m68k_interrupt_priority_unit: interrupt queueing and exception entry
//
// Commands arrive on the cmd channel: raise (queue a vector at a level),
// service (take the highest queued level if it beats the SR mask), and
// status-word or stack-pointer writes. Results leave on the result channel;
// each command's state update is done in the cycle it is transferred and its
// results are loaded into the output register at that edge.
// The first result is valid in the cycle after the command transfer.
// Raise, register writes and refused services give one result each, so a
// new command can follow every cycle while the receiver is ready. An
// accepted service gives three results (PC write, SR write, vector read),
// one per cycle through the single output register unless stalled. The
// vector comes from the queue RAM's registered read port.
// When the receiver stalls, the held result stays and cmd.ready stays low
// until the last result of the held command is transferred.
// Reset: all queues empty, SR = 0x2700, all stack pointers zero, nothing
// pending, no result valid.
// ----------------------------------------------------------------------------
module m68k_interrupt_priority_unit import mipu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  mipu_cmd_if.sink    cmd,
  mipu_res_if.source  result
);

  // Architectural state.
  logic [15:0] sr;
  logic [31:0] sp;
  logic [31:0] usp;
  logic [31:0] ssp;
  logic        pending;

  logic [15:0] sr_next;
  logic [31:0] sp_next;
  logic [31:0] usp_next;
  logic [31:0] ssp_next;
  logic        pending_next;

  logic        accepted;
  logic        load_ready;
  logic        take;
  logic [15:0] new_sr;
  logic [31:0] frame_base;
  q_ctl_t      qctl;
  q_stat_t     qstat;
  load_t       ld;
  logic [7:0]  pop_vec;

  assign cmd.ready = load_ready;
  assign accepted  = cmd.valid && load_ready;

  // Service is taken for level seven or a level above the current mask.
  assign take = qstat.any &&
                (qstat.top_level == LEVEL_NMI || qstat.top_level > sr[10:8]);

  // Next state and result contents for the command being transferred.
  always_comb begin
    sr_next         = sr;
    sp_next         = sp;
    usp_next        = usp;
    ssp_next        = ssp;
    pending_next    = pending;
    new_sr          = cmd.data.operand_value[15:0];
    frame_base      = sr[SR_S_BIT] ? sp : ssp;
    qctl.push       = 1'b0;
    qctl.pop        = 1'b0;
    qctl.push_level = cmd.data.priority_req;
    qctl.push_vec   = cmd.data.vector_number;
    ld.service      = 1'b0;
    ld.taken_level  = '0;
    ld.dropped      = 1'b0;
    unique case (cmd.data.action)
      ACT_RAISE: begin
        if (cmd.data.priority_req != 3'd0) begin
          qctl.push    = accepted;
          pending_next = 1'b1;
          ld.dropped   = qstat.push_full;
        end
      end
      ACT_SERVICE: begin
        if (take) begin
          qctl.pop          = accepted;
          ld.service        = 1'b1;
          ld.taken_level    = qstat.top_level;
          sr_next           = {sr[15:11], qstat.top_level, sr[7:0]};
          sr_next[SR_S_BIT] = 1'b1;
          if (!sr[SR_S_BIT]) begin
            usp_next = sp;
          end
          sp_next      = frame_base - FRAME_BYTES;
          pending_next = qstat.left_after_pop;
        end
      end
      ACT_WRITE_SR: begin
        if (new_sr[SR_S_BIT] && !sr[SR_S_BIT]) begin
          usp_next = sp;
          sp_next  = ssp;
        end else if (!new_sr[SR_S_BIT] && sr[SR_S_BIT]) begin
          ssp_next = sp;
          sp_next  = usp;
        end
        sr_next = new_sr;
      end
      ACT_WRITE_SP: begin
        sp_next = cmd.data.operand_value;
      end
      default: begin
        sp_next = sp;
      end
    endcase
    ld.status_word   = sr_next;
    ld.stack_pointer = sp_next;
    ld.pending       = pending_next;
    ld.pc            = cmd.data.operand_value;
    ld.old_sr        = sr;
  end

  // State registers commit on each command transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sr      <= SR_RESET;
      sp      <= '0;
      usp     <= '0;
      ssp     <= '0;
      pending <= 1'b0;
    end else if (accepted) begin
      sr      <= sr_next;
      sp      <= sp_next;
      usp     <= usp_next;
      ssp     <= ssp_next;
      pending <= pending_next;
    end
  end

  mipu_queues #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queues (
    .clk     (clk),
    .rst     (rst),
    .ctl     (qctl),
    .stat    (qstat),
    .pop_vec (pop_vec)
  );

  mipu_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accepted),
    .ld         (ld),
    .vec        (pop_vec),
    .load_ready (load_ready),
    .result     (result)
  );

  // A frame in progress blocks new commands until its last transfer.
  a_frame_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.last |-> !cmd.ready)
    else $error("command taken while an exception frame is still being sent");

  // An accepted service leaves supervisor state with the mask at the level.
  a_taken_sets_sr: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.taken_level != 3'd0 |->
      result.data.status_word[SR_S_BIT] &&
      result.data.status_word[10:8] == result.data.taken_level)
    else $error("taken level does not match the status word");

  // A vector read is always the last result and belongs to a taken level.
  a_vec_read_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.bus_kind == KIND_VEC_RD |->
      result.data.last && result.data.taken_level != 3'd0)
    else $error("vector read outside an accepted service");

  // A dropped raise never carries a bus access.
  a_drop_no_bus: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.dropped |->
      result.data.bus_kind == KIND_NONE && result.data.last)
    else $error("dropped raise produced a bus access");

endmodule

// ===== rtl/core/mipu_ram.sv =====
// ----------------------------------------------------------------------------
// mipu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module mipu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 28
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mipu_queues.sv =====
// ----------------------------------------------------------------------------
// mipu_queues: seven per-level vector FIFOs
// Keeps head and fill count per level, stores vectors in one shared RAM and
// reports the highest non-empty level to the exception entry logic.
// ----------------------------------------------------------------------------
module mipu_queues import mipu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  q_ctl_t     ctl,
  output q_stat_t    stat,
  output logic [7:0] pop_vec
);

  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = SLOT_W + CNT_W;
  localparam int DEPTH  = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0]  count [NUM_LEVELS];
  logic [SLOT_W-1:0] head  [NUM_LEVELS];

  logic [NUM_LEVELS-1:0] nonempty;
  logic [NUM_LEVELS-1:0] rest;
  logic [2:0]            top_idx;
  logic [2:0]            push_idx;
  logic [SUM_W-1:0]      tail_sum;
  logic [SLOT_W-1:0]     tail;
  logic [SLOT_W-1:0]     head_inc;
  logic                  push_full;
  logic                  do_push;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;

  // Highest non-empty level; index 0 is level 1.
  always_comb begin
    top_idx = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = (count[l] != '0);
      if (count[l] != '0) begin
        top_idx = 3'(l);
      end
    end
  end

  // Queues left non-empty once the top entry has been taken.
  always_comb begin
    rest = nonempty;
    if (count[top_idx] == CNT_W'(1)) begin
      rest[top_idx] = 1'b0;
    end
  end

  // Tail slot of the queue addressed by a raise.
  assign push_idx  = ctl.push_level - 3'd1;
  assign push_full = (count[push_idx] == CNT_W'(QUEUE_DEPTH));
  assign tail_sum  = SUM_W'(head[push_idx]) + SUM_W'(count[push_idx]);
  assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
  assign do_push   = ctl.push && !push_full;

  assign head_inc = (head[top_idx] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                    '0 : head[top_idx] + SLOT_W'(1);

  assign wr_addr = ADDR_W'(push_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail);
  assign rd_addr = ADDR_W'(top_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head[top_idx]);

  assign stat.any            = |nonempty;
  assign stat.top_level      = top_idx + 3'd1;
  assign stat.push_full      = push_full;
  assign stat.left_after_pop = |rest;

  // Head and count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        count[l] <= '0;
        head[l]  <= '0;
      end
    end else if (do_push) begin
      count[push_idx] <= count[push_idx] + CNT_W'(1);
    end else if (ctl.pop) begin
      count[top_idx] <= count[top_idx] - CNT_W'(1);
      head[top_idx]  <= head_inc;
    end
  end

  mipu_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (wr_addr),
    .wr_data (ctl.push_vec),
    .rd_en   (ctl.pop),
    .rd_addr (rd_addr),
    .rd_data (pop_vec)
  );

endmodule

// ===== rtl/core/mipu_out.sv =====
// ----------------------------------------------------------------------------
// mipu_out: result register and exception frame sequencer
// Holds one command's results and presents one per cycle unless stalled:
// a single status result, or the PC write, SR write and vector read.
// ----------------------------------------------------------------------------
module mipu_out import mipu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  load_t              ld,
  input  logic [7:0]         vec,
  output logic               load_ready,
  mipu_res_if.source         result
);

  logic       valid;
  logic [1:0] phase;
  load_t      held;
  logic       is_last;

  assign is_last    = !held.service || (phase == PH_VEC_READ);
  assign load_ready = !valid || (result.ready && is_last);

  // Phase and valid control.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= PH_PC_WRITE;
    end else if (load) begin
      valid <= 1'b1;
      phase <= PH_PC_WRITE;
    end else if (valid && result.ready) begin
      if (is_last) begin
        valid <= 1'b0;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= ld;
    end
  end

  // Result fields for the current phase.
  always_comb begin
    result.valid              = valid;
    result.data.last          = is_last;
    result.data.status_word   = held.status_word;
    result.data.stack_pointer = held.stack_pointer;
    result.data.pending       = held.pending;
    result.data.taken_level   = held.taken_level;
    result.data.dropped       = held.dropped;
    result.data.bus_kind      = KIND_NONE;
    result.data.bus_address   = '0;
    result.data.bus_data      = '0;
    if (held.service) begin
      unique case (phase)
        PH_PC_WRITE: begin
          result.data.bus_kind    = KIND_LONG_WR;
          result.data.bus_address = held.stack_pointer + PC_OFFSET;
          result.data.bus_data    = held.pc;
        end
        PH_SR_WRITE: begin
          result.data.bus_kind    = KIND_WORD_WR;
          result.data.bus_address = held.stack_pointer;
          result.data.bus_data    = {16'h0000, held.old_sr};
        end
        PH_VEC_READ: begin
          result.data.bus_kind    = KIND_VEC_RD;
          result.data.bus_address = {22'h0, vec, 2'b00};
        end
        default: begin
          result.data.bus_kind = KIND_NONE;
        end
      endcase
    end
  end

endmodule
